/* hdl/assert_macros.svh */
// Assertion macros for the port-level checker of the percent decoder.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

/* hdl/urlpd_pkg.sv */
// Shared types, character constants and hex helpers for the percent decoder.
// Depends on nothing; imported by every module of the block.
package urlpd_pkg;

   localparam int BUNDLE_MAX  = 3;
   localparam int COUNT_W     = $clog2(BUNDLE_MAX + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   // Up to three decoded bytes released by one input byte, oldest in slot 0.
   typedef struct packed {
      logic [BUNDLE_MAX-1:0][7:0] data;
      logic [COUNT_W-1:0]         count;
      logic                       last;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
   endfunction

   // Letters of either case have a low nibble of 1 to 6, so adding nine gives 10 to 15.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] nib;
      nib = c[3:0];
      if (c <= CH_NINE) begin
         return nib;
      end
      return nib + 4'd9;
   endfunction

endpackage

/* hdl/urlpd_front.sv */
// Front end: accepts encoded bytes, tracks the escape state and builds a
// bundle of the bytes each input releases. Depends on urlpd_pkg.
module urlpd_front import urlpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_end,
   output logic       push,
   output bundle_type push_bundle
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   bundle_type bundle;

   always_comb begin
      logic             run_idle;
      logic [COUNT_W-1:0] n;
      phase_type        ph;
      logic [7:0]       held;
      run_idle    = 1'b0;
      n           = '0;
      ph          = PH_IDLE;
      held        = held_ff;
      bundle.data = '0;
      bundle.last = 1'b0;

      unique case (phase_ff)
         PH_PERCENT: begin
            if (is_hex(in_byte)) begin
               ph   = PH_DIGIT;
               held = in_byte;
            end else begin
               bundle.data[n[1:0]] = CH_PERCENT;
               n        = n + 1'b1;
               run_idle = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (is_hex(in_byte)) begin
               bundle.data[n[1:0]] = {hex_value(held_ff), hex_value(in_byte)};
               n = n + 1'b1;
            end else begin
               bundle.data[n[1:0]] = CH_PERCENT;
               n = n + 1'b1;
               bundle.data[n[1:0]] = held_ff;
               n        = n + 1'b1;
               run_idle = 1'b1;
            end
            held = '0;
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      if (run_idle) begin
         if (in_byte == CH_PERCENT) begin
            ph = PH_PERCENT;
         end else if (in_byte == CH_PLUS) begin
            bundle.data[n[1:0]] = CH_SPACE;
            n = n + 1'b1;
         end else begin
            bundle.data[n[1:0]] = in_byte;
            n = n + 1'b1;
         end
      end

      // A string that ends inside an escape flushes it literally.
      if (in_end) begin
         if (ph == PH_PERCENT) begin
            bundle.data[n[1:0]] = CH_PERCENT;
            n = n + 1'b1;
         end else if (ph == PH_DIGIT) begin
            bundle.data[n[1:0]] = CH_PERCENT;
            n = n + 1'b1;
            bundle.data[n[1:0]] = held;
            n = n + 1'b1;
         end
         ph          = PH_IDLE;
         held        = '0;
         bundle.last = 1'b1;
      end

      bundle.count = n;
      phase_in     = ph;
      held_in      = held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else if (in_valid && in_ready) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   assign push        = in_valid && in_ready && (bundle.count != '0);
   assign push_bundle = bundle;

endmodule

/* hdl/urlpd_queue.sv */
// Two-entry bundle queue between the front and the back end.
// Depends on urlpd_pkg.
module urlpd_queue import urlpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output bundle_type head_bundle
);

   bundle_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   assign full        = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_bundle = entry_ff[rd_ptr_ff];

endmodule

/* hdl/urlpd_back.sv */
// Back end: walks the head bundle one byte at a time into a registered
// output stage. Depends on urlpd_pkg.
module urlpd_back import urlpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head_bundle,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               out_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff;
   logic               load;
   logic               final_slot;

   assign load       = head_valid && (!out_valid_ff || out_ready);
   assign final_slot = (idx_ff == head_bundle.count - 1'b1);
   assign pop        = load && final_slot;
   assign idx_in     = final_slot ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (load) begin
         idx_ff       <= idx_in;
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= head_bundle.data[idx_ff[1:0]];
         out_last_ff <= head_bundle.last && final_slot;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

endmodule

/* hdl/url_percent_decoder.sv */
// Percent decoder: a decoded byte passes from the front into a queue entry, then
// into the back end's output register. One input byte per cycle is sustained
// while each releases at most one byte and the output is not stalled; an input
// releasing several bytes holds the single output port until all have left, and
// the two-bundle queue absorbs that. Reset is synchronous and active high; it
// returns the escape state to idle and empties the queue and the output stage.
//
// Structure: urlpd_front keeps the escape phase and the held hex digit and turns
// every accepted byte into a bundle of zero to three output bytes (a '%' waits
// silently, a complete escape yields one byte, a malformed one yields the literal
// '%' and any held digit ahead of the current byte, and one cut off by the end of
// the string is flushed literally at the end). Empty bundles are never queued.
// urlpd_queue decouples the two ends, so input is refused only when both queue
// entries are occupied. urlpd_back serialises the head bundle into the output
// register, one byte a cycle unless stalled; tlast flags the string's last byte.
module url_percent_decoder import urlpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   logic       push;
   bundle_type push_bundle;
   logic       pop;
   logic       full;
   logic       head_valid;
   bundle_type head_bundle;

   // Input is taken whenever the queue has room for the bundle it may produce.
   assign req_tready = !full;

   urlpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_end      (req_tlast),
      .push        (push),
      .push_bundle (push_bundle)
   );

   urlpd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (full),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   urlpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

/* hdl/urlpd_checker.sv */
// Port-level checker for the percent decoder and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module urlpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // Reset empties the output stage.
   `ASSERT_NEXT(chk_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // Reset empties the queue, so input is taken straight away afterwards.
   `ASSERT_NEXT(chk_reset_ready, clock, 1'b0, reset, req_tready)

   // A stalled result holds its byte and its end marker.
   `ASSERT_NEXT(chk_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // An idle output stage means the queue held nothing in the previous cycle, so it has room.
   `ASSERT_IMPLY(chk_idle_ready, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind url_percent_decoder urlpd_checker u_urlpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* dv/url_percent_decoder_checker.sv */
// Scoreboard for the percent decoder: predicts decoded bytes from the input
// transactions and checks them against the result transactions.
// Depends on urlpd_pkg for the character constants.
module url_percent_decoder_checker import urlpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_string
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  logic       rsp_tlast,   // out_last
   output int         fail_count,
   output int         pending,
   output int         bytes_in,
   output int         strings_in,
   output int         bytes_out,
   output int         escapes_decoded,
   output int         escapes_broken
);

   typedef enum logic [1:0] {ESC_IDLE, ESC_PERCENT, ESC_DIGIT} esc_phase_t;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } decoded_t;

   esc_phase_t phase;
   logic [7:0] held_digit;
   decoded_t   decoded_q[$];
   decoded_t   oldest;
   int         step_emits;

   initial begin
      phase           = ESC_IDLE;
      held_digit      = '0;
      step_emits      = 0;
      fail_count      = 0;
      pending         = 0;
      bytes_in        = 0;
      strings_in      = 0;
      bytes_out       = 0;
      escapes_decoded = 0;
      escapes_broken  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Returns 1 and the digit's value when c is a hex digit of either case.
   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
      nib = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         nib = 4'(c - CH_ZERO);
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         nib = 4'(c - CH_UPPER_A + 8'd10);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         nib = 4'(c - CH_LOWER_A + 8'd10);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic emit_decoded(input logic [7:0] v);
      decoded_t d;
      d.value = v;
      d.last  = 1'b0;
      decoded_q.push_back(d);
      step_emits++;
   endtask

   // A byte seen with no escape in progress.
   task automatic plain_byte(input logic [7:0] c);
      if (c == CH_PERCENT) begin
         phase = ESC_PERCENT;
      end else if (c == CH_PLUS) begin
         emit_decoded(CH_SPACE);
      end else begin
         emit_decoded(c);
      end
   endtask

   task automatic predict_decode(input logic [7:0] c, input logic eos);
      logic [3:0] hi;
      logic [3:0] lo;
      bit         is_digit;
      decoded_t   tail;
      step_emits = 0;
      is_digit = hex_nibble(c, lo);
      case (phase)
         ESC_PERCENT: begin
            if (is_digit) begin
               held_digit = c;
               phase = ESC_DIGIT;
            end else begin
               emit_decoded(CH_PERCENT);
               escapes_broken++;
               phase = ESC_IDLE;
               plain_byte(c);
            end
         end
         ESC_DIGIT: begin
            phase = ESC_IDLE;
            if (is_digit) begin
               void'(hex_nibble(held_digit, hi));
               emit_decoded({hi, lo});
               escapes_decoded++;
               held_digit = '0;
            end else begin
               emit_decoded(CH_PERCENT);
               emit_decoded(held_digit);
               escapes_broken++;
               held_digit = '0;
               plain_byte(c);
            end
         end
         default: begin
            phase = ESC_IDLE;
            plain_byte(c);
         end
      endcase
      if (eos) begin
         // An escape cut off by the end of the string is released as it stood.
         if (phase == ESC_PERCENT) begin
            emit_decoded(CH_PERCENT);
            escapes_broken++;
         end else if (phase == ESC_DIGIT) begin
            emit_decoded(CH_PERCENT);
            emit_decoded(held_digit);
            escapes_broken++;
         end
         phase = ESC_IDLE;
         held_digit = '0;
         if (step_emits > 0) begin
            tail = decoded_q.pop_back();
            tail.last = 1'b1;
            decoded_q.push_back(tail);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = ESC_IDLE;
         held_digit = '0;
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_in++;
            if (req_tlast) begin
               strings_in++;
            end
            predict_decode(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_out++;
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("decoded byte 0x%02h (last %0b) with none expected",
                                         rsp_tdata, rsp_tlast));
            end else begin
               oldest = decoded_q.pop_front();
               if (rsp_tdata !== oldest.value) begin
                  report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                            rsp_tdata, oldest.value));
               end
               if (rsp_tlast !== oldest.last) begin
                  report_mismatch($sformatf("out_last %0b, expected %0b on byte 0x%02h",
                                            rsp_tlast, oldest.last, oldest.value));
               end
            end
         end
      end
      pending = decoded_q.size();
   end

endmodule

/* dv/url_percent_decoder_test.sv */
// Top of the percent decoder testbench: clock, reset, input and output traffic
// and the verdict. Depends on urlpd_pkg, url_percent_decoder and the checker.
module url_percent_decoder_test;
   import urlpd_pkg::*;

   // Roughly this many random input bytes follow the directed strings.
   localparam int RANDOM_ITEMS = 210;
   // The last stretch of random bytes runs with neither side idling.
   localparam int QUIET_TAIL   = 40;
   // This bound lies far above a run with every stall at its longest, and only
   // catches a hung block.
   localparam int CYCLE_LIMIT  = 200000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;    // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;            // out_last

   int fail_count;
   int pending;
   int bytes_in;
   int strings_in;
   int bytes_out;
   int escapes_decoded;
   int escapes_broken;

   int cycle_count = 0;
   int stall_left  = 0;
   bit feed_gaps   = 1'b1;
   bit drain_stalls = 1'b1;

   always #6 clock = ~clock;

   url_percent_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   url_percent_decoder_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending         (pending),
      .bytes_in        (bytes_in),
      .strings_in      (strings_in),
      .bytes_out       (bytes_out),
      .escapes_decoded (escapes_decoded),
      .escapes_broken  (escapes_broken)
   );

   // Watchdog: a block that stops moving data ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d decoded bytes outstanding.",
                  cycle_count, pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Output back-pressure. A stall is a burst of random length with tready low; between
   // bursts tready stays high, so there are long stretches where the output flows freely.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (drain_stalls && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sends one input transaction, sometimes after a gap with tvalid low. It is called
   // at a rising edge; tready is looked at on the falling edge, where it has settled, and
   // the transaction is then taken at the next rising edge.
   task automatic send_byte(input logic [7:0] value, input logic eos);
      if (feed_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eos;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // Sends a whole string, flagging its final byte as the end of the string.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   // A random hex digit character, letters in either case.
   function automatic logic [7:0] random_hex_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return CH_ZERO + 8'(v);
      end
      if ($urandom_range(0, 1) == 1) begin
         return CH_UPPER_A + 8'(v - 10);
      end
      return CH_LOWER_A + 8'(v - 10);
   endfunction

   initial begin
      logic [7:0] text_q[$];
      int         items_sent;
      int         pieces;
      int         kind;

      items_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed strings. A complete escape with a lowercase letter followed by a plus
      // sign; the largest escaped value in mixed case, then a percent sign followed by a
      // non-hex byte and an escape broken after its first digit.
      send_text("%4a+");
      send_text("%fF%G%4Z");
      // Two percent signs closing a string: the second is cut off by the end.
      send_text("%%");
      // A held digit flushed by a new escape that is itself cut off: three bytes at once.
      send_text("%4%");
      // Extreme byte values passing through, and a high byte breaking an escape.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_PERCENT, 1'b0);
      send_byte(8'h80, 1'b0);
      // An escape cut off by the end of the string after its first digit.
      send_text("%4");

      // Random strings. Most pieces are plain bytes or well-formed escapes with random
      // digits; the rest are plus signs and escapes that are often broken or cut off.
      while (items_sent < RANDOM_ITEMS) begin
         text_q.delete();
         pieces = $urandom_range(1, 6);
         for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               text_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 75) begin
               text_q.push_back(CH_PERCENT);
               text_q.push_back(random_hex_digit());
               text_q.push_back(random_hex_digit());
            end else if (kind < 83) begin
               text_q.push_back(CH_PLUS);
            end else begin
               text_q.push_back(CH_PERCENT);
               if ($urandom_range(0, 1) == 1) begin
                  text_q.push_back(random_hex_digit());
               end
               if ($urandom_range(0, 1) == 1) begin
                  text_q.push_back(8'($urandom_range(0, 255)));
               end
            end
         end
         feed_gaps    = items_sent < RANDOM_ITEMS - QUIET_TAIL;
         drain_stalls = feed_gaps;
         foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
         end
         items_sent += text_q.size();
      end
      req_tvalid <= 1'b0;

      // Wait for every predicted byte, then give the two-stage pipeline time to show
      // anything it should not have produced.
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d strings and checked %0d decoded bytes.",
               bytes_in, strings_in, bytes_out);
      $display("Escapes decoded: %0d; malformed or cut-off escapes released: %0d.",
               escapes_decoded, escapes_broken);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/urlpd_pkg.sv
hdl/urlpd_front.sv
hdl/urlpd_queue.sv
hdl/urlpd_back.sv
hdl/url_percent_decoder.sv
hdl/urlpd_checker.sv
dv/url_percent_decoder_checker.sv
dv/url_percent_decoder_test.sv
